### hdl/gaim_pkg.sv
// Shared types, constants and controller/datapath interface for the interval merge block.
package gaim_pkg;

  localparam int POS_W          = 31;
  localparam int OP_W           = 2;
  localparam int DEF_MAX_BREAKS = 64;
  localparam int DEF_MAX_GAPS   = 256;
  localparam int MAX_RESULTS    = 64;
  localparam int RES_CW         = $clog2(MAX_RESULTS + 1);
  localparam logic [POS_W-1:0] MERGE_GAP_RESET = POS_W'(10000);

  localparam logic [OP_W-1:0] OP_GAP    = 2'd0;
  localparam logic [OP_W-1:0] OP_BREAK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             scaffold;
  } brk_t;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } gap_t;

  typedef struct packed {
    logic load_gap;
    logic load_brk;
    logic clear;
    logic sort_init;
    logic key_rd;
    logic key_lat;
    logic prev_rd;
    logic shift;
    logic place;
    logic m_rd0;
    logic m_init;
    logic m_rd;
    logic m_lat;
    logic take;
    logic extend;
    logic gap_init;
    logic gap_mid_rd;
    logic gap_step;
    logic gap_lo_rd;
    logic emit;
    logic emit_last;
  } gaim_cmd_t;

  typedef struct packed {
    logic brk_empty;
    logic i_done;
    logic j_zero;
    logic prev_gt;
    logic j_end;
    logic far;
    logic brk_scf;
    logic gap_range;
    logic lo_eq_hi;
    logic lo_lt_cnt;
    logic gap_hit;
  } gaim_sts_t;

endpackage

### hdl/gaim_ctrl.sv
// Sequencer for loading, insertion sort, merge and gap search.
module gaim_ctrl import gaim_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  gaim_sts_t       sts,
  output gaim_cmd_t       cmd,
  output logic            busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KEY    = 4'd1;
  localparam logic [3:0] S_KEYL   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_MINIT  = 4'd5;
  localparam logic [3:0] S_MNEXT  = 4'd6;
  localparam logic [3:0] S_MLAT   = 4'd7;
  localparam logic [3:0] S_MEVAL  = 4'd8;
  localparam logic [3:0] S_GRD    = 4'd9;
  localparam logic [3:0] S_GSTEP  = 4'd10;
  localparam logic [3:0] S_GLO    = 4'd11;
  localparam logic [3:0] S_GEND   = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_GAP:   cmd.load_gap = 1'b1;
            OP_BREAK: cmd.load_brk = 1'b1;
            OP_FINISH: begin
              if (sts.brk_empty) begin
                cmd.clear = 1'b1;
              end else begin
                cmd.sort_init = 1'b1;
                state_next    = S_KEY;
              end
            end
            default: ;
          endcase
        end
      end
      S_KEY: begin
        if (sts.i_done) begin
          cmd.m_rd0  = 1'b1;
          state_next = S_MINIT;
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_KEYL;
        end
      end
      S_KEYL: begin
        cmd.key_lat = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (sts.j_zero) begin
          cmd.place  = 1'b1;
          state_next = S_KEY;
        end else begin
          cmd.prev_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        // shift the larger entry up one slot, else drop the key here
        if (sts.prev_gt) begin
          cmd.shift  = 1'b1;
          state_next = S_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_KEY;
        end
      end
      S_MINIT: begin
        cmd.m_init = 1'b1;
        state_next = S_MNEXT;
      end
      S_MNEXT: begin
        if (sts.j_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.m_rd   = 1'b1;
          state_next = S_MLAT;
        end
      end
      S_MLAT: begin
        cmd.m_lat  = 1'b1;
        state_next = S_MEVAL;
      end
      S_MEVAL: begin
        if (sts.far) begin
          cmd.emit   = 1'b1;
          cmd.take   = 1'b1;
          state_next = S_MNEXT;
        end else if (sts.brk_scf || !sts.gap_range) begin
          cmd.extend = 1'b1;
          state_next = S_MNEXT;
        end else begin
          cmd.gap_init = 1'b1;
          state_next   = S_GRD;
        end
      end
      S_GRD: begin
        if (sts.lo_eq_hi) begin
          state_next = S_GLO;
        end else begin
          cmd.gap_mid_rd = 1'b1;
          state_next     = S_GSTEP;
        end
      end
      S_GSTEP: begin
        cmd.gap_step = 1'b1;
        state_next   = S_GRD;
      end
      S_GLO: begin
        if (sts.lo_lt_cnt) begin
          cmd.gap_lo_rd = 1'b1;
          state_next    = S_GEND;
        end else begin
          cmd.extend = 1'b1;
          state_next = S_MNEXT;
        end
      end
      S_GEND: begin
        if (sts.gap_hit) begin
          cmd.emit = 1'b1;
          cmd.take = 1'b1;
        end else begin
          cmd.extend = 1'b1;
        end
        state_next = S_MNEXT;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/gaim_dp.sv
// Datapath: break and gap stores, sort and merge registers, result registers.
module gaim_dp import gaim_pkg::*; #(
  parameter int MAX_BREAKS = DEF_MAX_BREAKS,
  parameter int MAX_GAPS   = DEF_MAX_GAPS
) (
  input  logic             clk,
  input  logic             rst,
  input  gaim_cmd_t        cmd,
  output gaim_sts_t        sts,
  input  logic [POS_W-1:0] start_pos,
  input  logic [POS_W-1:0] end_pos,
  input  logic             scaffold_level,
  input  logic             cfg_valid,
  input  logic [POS_W-1:0] cfg_data,
  output logic             result_valid,
  output logic [POS_W-1:0] merged_start,
  output logic [POS_W-1:0] merged_end,
  output logic             merged_scaffold,
  output logic             last_of_run,
  output logic             overflow
);

  localparam int BCW = $clog2(MAX_BREAKS + 1);
  localparam int BAW = $clog2(MAX_BREAKS);
  localparam int GCW = $clog2(MAX_GAPS + 1);
  localparam int GAW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;

  brk_t brk_mem [MAX_BREAKS];
  gap_t gap_mem [MAX_GAPS];

  logic [BCW-1:0]   brk_count, idx_i, idx_j;
  logic [GCW-1:0]   gap_count, lo, hi;
  logic [GCW:0]     mid_sum;
  logic [GAW-1:0]   mid;
  logic             dropped;
  logic [POS_W-1:0] merge_gap;
  logic [POS_W-1:0] first_start, last_end;
  logic [RES_CW-1:0] res_count;

  brk_t brk_rd, key, cur, brk;
  gap_t gap_rd;
  logic [BAW-1:0] brk_raddr;
  logic [BCW-1:0] j_dec;
  logic [GAW-1:0] gap_raddr;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = GAW'(mid_sum[GCW:1]);
  assign j_dec   = idx_j - BCW'(1);

  always_comb begin
    brk_raddr = BAW'(idx_j);
    if (cmd.key_rd)       brk_raddr = BAW'(idx_i);
    else if (cmd.prev_rd) brk_raddr = BAW'(j_dec);
    else if (cmd.m_rd0)   brk_raddr = '0;
    else if (cmd.m_rd)    brk_raddr = BAW'(idx_j);
  end

  always_comb begin
    gap_raddr = GAW'(lo);
    if (cmd.gap_mid_rd)     gap_raddr = mid;
    else if (cmd.gap_lo_rd) gap_raddr = GAW'(lo);
  end

  // break store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load_brk && brk_count != BCW'(MAX_BREAKS))
      brk_mem[BAW'(brk_count)] <= '{start_pos, end_pos, scaffold_level};
    else if (cmd.shift)
      brk_mem[BAW'(idx_j)] <= brk_rd;
    else if (cmd.place)
      brk_mem[BAW'(idx_j)] <= key;
    brk_rd <= brk_mem[brk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_gap && gap_count != GCW'(MAX_GAPS))
      gap_mem[GAW'(gap_count)] <= '{start_pos, end_pos};
    gap_rd <= gap_mem[gap_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brk_count <= '0;
      gap_count <= '0;
      dropped   <= 1'b0;
      merge_gap <= MERGE_GAP_RESET;
      res_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) merge_gap <= cfg_data;
      if (cmd.load_brk) begin
        if (brk_count != BCW'(MAX_BREAKS)) brk_count <= brk_count + BCW'(1);
        else                               dropped   <= 1'b1;
      end
      if (cmd.load_gap) begin
        if (gap_count != GCW'(MAX_GAPS)) gap_count <= gap_count + GCW'(1);
        else                             dropped   <= 1'b1;
      end
      result_valid <= cmd.emit && (res_count != RES_CW'(MAX_RESULTS));
      if (cmd.clear) begin
        brk_count <= '0;
        gap_count <= '0;
        dropped   <= 1'b0;
        res_count <= '0;
      end else if (cmd.emit && res_count != RES_CW'(MAX_RESULTS)) begin
        res_count <= res_count + RES_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_gap && gap_count != GCW'(MAX_GAPS)) begin
      if (gap_count == '0) first_start <= start_pos;
      last_end <= end_pos;
    end
    if (cmd.sort_init) idx_i <= BCW'(1);
    if (cmd.place)     idx_i <= idx_i + BCW'(1);
    if (cmd.key_lat) begin
      key   <= brk_rd;
      idx_j <= idx_i;
    end
    if (cmd.shift)  idx_j <= j_dec;
    if (cmd.m_init) begin
      cur   <= brk_rd;
      idx_j <= BCW'(1);
    end
    if (cmd.m_lat) brk <= brk_rd;
    if (cmd.take) begin
      cur   <= brk;
      idx_j <= idx_j + BCW'(1);
    end
    if (cmd.extend) begin
      if (brk.end_pos > cur.end_pos) cur.end_pos <= brk.end_pos;
      cur.scaffold <= cur.scaffold | brk.scaffold;
      idx_j        <= idx_j + BCW'(1);
    end
    if (cmd.gap_init) begin
      lo <= '0;
      hi <= gap_count;
    end
    if (cmd.gap_step) begin
      // gap start at or below (end - 1): search right half
      if (gap_rd.start_pos < cur.end_pos) lo <= GCW'(mid) + GCW'(1);
      else                                hi <= GCW'(mid);
    end
    if (cmd.emit) begin
      merged_start    <= cur.start_pos;
      merged_end      <= cur.end_pos;
      merged_scaffold <= cur.scaffold;
      last_of_run     <= cmd.emit_last;
      overflow        <= dropped;
    end
  end

  logic [POS_W:0] reach;
  assign reach = {1'b0, cur.end_pos} + {1'b0, merge_gap};

  always_comb begin
    sts.brk_empty = (brk_count == '0);
    sts.i_done    = (idx_i >= brk_count);
    sts.j_zero    = (idx_j == '0);
    sts.prev_gt   = (brk_rd > key);
    sts.j_end     = (idx_j == brk_count);
    sts.far       = ({1'b0, brk.start_pos} > reach);
    sts.brk_scf   = brk.scaffold;
    sts.gap_range = (gap_count != '0) && (cur.end_pos != '0)
                    && (first_start < cur.end_pos)
                    && ((cur.end_pos - POS_W'(1)) <= last_end);
    sts.lo_eq_hi  = (lo == hi);
    sts.lo_lt_cnt = (lo < gap_count);
    sts.gap_hit   = (gap_rd.end_pos <= brk.start_pos);
  end

endmodule

### hdl/gap_aware_interval_merge.sv
// Top level: gap-aware sorted interval merge.
// Loads (gap, break) and ignored ops complete while idle; busy stays low.
// Finish: insertion sort over the break store, then merge; a break within merge_gap that is
// not scaffold and lies in the gap range starts a binary search of the gap store.
// Results strobe for one cycle each; the receiver cannot stall them.
// Synchronous reset clears counts and flag and sets merge_gap to 10000; stores are not cleared.
module gap_aware_interval_merge import gaim_pkg::*; #(
  parameter int MAX_BREAKS = DEF_MAX_BREAKS,
  parameter int MAX_GAPS   = DEF_MAX_GAPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  op,
  input  logic [POS_W-1:0] start_pos,
  input  logic [POS_W-1:0] end_pos,
  input  logic             scaffold_level,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data,
  output logic             result_valid,
  output logic [POS_W-1:0] merged_start,
  output logic [POS_W-1:0] merged_end,
  output logic             merged_scaffold,
  output logic             last_of_run,
  output logic             overflow
);

  gaim_cmd_t cmd;
  gaim_sts_t sts;

  assign cfg_ready = 1'b1;

  gaim_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  gaim_dp #(
    .MAX_BREAKS(MAX_BREAKS),
    .MAX_GAPS  (MAX_GAPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .start_pos      (start_pos),
    .end_pos        (end_pos),
    .scaffold_level (scaffold_level),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .merged_start   (merged_start),
    .merged_end     (merged_end),
    .merged_scaffold(merged_scaffold),
    .last_of_run    (last_of_run),
    .overflow       (overflow)
  );

endmodule

### hdl/gaim_checker.sv
// Port-level checks for the interval merge block, bound to the top level.
module gaim_checker import gaim_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic [OP_W-1:0] op,
  input logic            result_valid,
  input logic            last_of_run
);

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> busy)
    else $error("non-final result while idle");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |=> !result_valid)
    else $error("result after final result");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op != OP_FINISH |=> !busy && !result_valid)
    else $error("load transfer caused work or result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("not idle after reset");

endmodule

bind gap_aware_interval_merge gaim_checker u_gaim_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .op          (op),
  .result_valid(result_valid),
  .last_of_run (last_of_run)
);
